[design/pls_pkg.sv]
package pls_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 6;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_READ_FWD = 2'd2,
        MODE_READ_BWD = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_READ
    } t_op;

    typedef enum logic {
        BS_IDLE,
        BS_READ
    } t_bstate;

    typedef struct packed {
        t_mode                    mode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_item;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  entry_value;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic                     last;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        t_op                      op;
        logic                     rev;
        logic                     pos_zero;
        logic [POS_W-1:0]         position;
        logic [DATA_WIDTH-1:0]    data;
    } t_cmd;

endpackage

[design/pls_front.sv]
module pls_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pls_pkg::t_item i_item,
    input  logic           i_q_full,
    output logic           o_busy,
    output logic           o_push,
    output pls_pkg::t_cmd  o_cmd
);
    import pls_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    assign o_busy = r_valid && i_q_full;
    assign o_push = r_valid && !i_q_full;
    assign accept = i_start && !o_busy;
    assign o_cmd  = r_cmd;

    always_comb begin
        n_cmd          = r_cmd;
        n_valid        = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid          = 1'b1;
            n_cmd.position   = i_item.position;
            n_cmd.pos_zero   = (i_item.position == '0);
            n_cmd.data       = DATA_WIDTH'($unsigned(i_item.value));
            n_cmd.rev        = 1'b0;
            unique case (i_item.mode) inside
                MODE_INSERT: begin
                    n_cmd.op = OP_INSERT;
                end
                MODE_DELETE: begin
                    n_cmd.op = OP_DELETE;
                end
                MODE_READ_FWD, MODE_READ_BWD: begin
                    n_cmd.op  = OP_READ;
                    n_cmd.rev = (i_item.mode == MODE_READ_BWD);
                end
                default: begin
                    n_cmd.op = OP_READ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

[design/pls_queue.sv]
module pls_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pls_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output pls_pkg::t_cmd o_data
);
    import pls_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

[design/pls_back.sv]
module pls_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  pls_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_strobe,
    output pls_pkg::t_result o_result
);
    import pls_pkg::*;

    logic [DATA_WIDTH-1:0] r_cells [CAPACITY];

    t_bstate          r_state;
    t_bstate          n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_rd_i;
    logic [IDX_W-1:0] n_rd_i;
    logic             r_rev;
    logic             n_rev;
    logic             r_strobe;
    logic             n_strobe;
    t_result          r_result;
    t_result          n_result;

    logic             ins_en;
    logic             del_en;
    logic [POS_W-1:0] pos_m1;
    logic [IDX_W-1:0] op_idx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] rev_pos;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_last;

    assign pos_m1  = i_cmd.position - POS_W'(1);
    assign op_idx  = pos_m1[IDX_W-1:0];
    assign pos_ext = CMP_W'(i_cmd.position);
    assign cnt_ext = CMP_W'(r_count);
    assign rev_pos = r_count - CNT_W'(1) - CNT_W'(r_rd_i);
    assign rd_idx  = r_rev ? rev_pos[IDX_W-1:0] : r_rd_i;
    assign rd_last = (CNT_W'(r_rd_i) + CNT_W'(1)) == r_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_i   = r_rd_i;
        n_rev    = r_rev;
        n_strobe = 1'b0;
        n_result = '{status: ST_OK, entry_value: '0, entry_count: '0, last: 1'b1};
        o_pop    = 1'b0;
        ins_en   = 1'b0;
        del_en   = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            n_strobe = 1'b1;
                            if (i_cmd.pos_zero || pos_ext > cnt_ext + CMP_W'(1)) begin
                                n_result.status = ST_RANGE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                ins_en  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            n_strobe = 1'b1;
                            if (i_cmd.pos_zero || pos_ext > cnt_ext) begin
                                n_result.status = ST_RANGE;
                            end else begin
                                del_en  = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_state = BS_READ;
                                n_rd_i  = '0;
                                n_rev   = i_cmd.rev;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                    n_result.entry_count = CNT_OUT_W'(n_count);
                end
            end
            BS_READ: begin
                n_strobe             = 1'b1;
                n_result.entry_value = VAL_W'(signed'(r_cells[rd_idx]));
                n_result.entry_count = CNT_OUT_W'(r_count);
                n_result.last        = rd_last;
                if (rd_last) begin
                    n_state = BS_IDLE;
                end else begin
                    n_rd_i = r_rd_i + IDX_W'(1);
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_i   <= n_rd_i;
        r_rev    <= n_rev;
        r_result <= n_result;
    end

    // each cell keeps its own value, takes the new value, its left neighbor or its right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (ins_en) begin
                if (IDX_W'(g) == op_idx) begin
                    r_cells[g] <= i_cmd.data;
                end else if (IDX_W'(g) > op_idx) begin
                    r_cells[g] <= r_cells[(g > 0) ? g - 1 : 0];
                end
            end else if (del_en) begin
                if (IDX_W'(g) >= op_idx) begin
                    r_cells[g] <= r_cells[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[design/positional_list_store.sv]
// ordered list store of up to CAPACITY signed values, held in a row of cells
//
// input channel: drive an item on i_item and raise start; the item is taken
// at a rising edge where start is high and busy is low. mode selects insert
// at a 1-based position, delete at a position, or a readout front to back or
// back to front.
// result channel: o_strobe marks o_result for exactly one cycle; the receiver
// cannot stall it, so it must take every result when it appears.
// a front stage classifies each item and puts it into a two-entry queue; the
// back end pops it and shifts the cells from its position on in the same cycle as the pop.
// path: front stage register, queue, then the back end, which registers each
// result. an insert or delete gives one result; a readout gives one result per
// entry on consecutive cycles from its read state, last flagged; a readout of an
// empty list gives a single result flagged empty, registered at the pop.
// throughput: one insert or delete per cycle while no readout holds the back
// end; a readout keeps the back end in its read state up to its last entry,
// and busy rises once the queue and the front stage are both full.
// reset (synchronous, active low) empties the list and the queue; the cell
// contents are not cleared, cells beyond the count are never read.
module positional_list_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pls_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_strobe,
    output pls_pkg::t_result o_result
);
    import pls_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd f_cmd;
    t_cmd q_cmd;

    pls_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    pls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    pls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    // a readout runs on consecutive cycles until its last result
    a_read_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe)
        else $error("readout run broken");

    // an empty readout is a single result with no entries
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_EMPTY |->
            o_result.last && o_result.entry_count == '0 && o_result.entry_value == '0)
        else $error("bad empty result");

    // only readouts of a non-empty list carry data
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_OK |-> o_result.entry_value == '0)
        else $error("error result carries data");

    // the queue is never popped while empty
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule
